/* rtl/hbo_pkg.sv */
// Shared widths, codes and bus types for the bucket histogram observer.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package hbo_pkg;

  localparam int VAL_W      = 32;
  localparam int WGT_W      = 16;
  localparam int SLOT_W     = 4;
  localparam int CNT_W      = 48;
  localparam int SUM_W      = 64;
  localparam int PROD_W     = VAL_W + WGT_W + 1;
  localparam int MAX_BOUNDS_DEF = 15;

  localparam logic [SLOT_W-1:0] BOUNDS_RST = SLOT_W'(11);

  localparam logic [1:0] MODE_OBSERVE = 2'd0;
  localparam logic [1:0] MODE_LOAD    = 2'd1;
  localparam logic [1:0] MODE_READ    = 2'd2;

  // Request from the top-level sequencer to the accumulate unit.
  typedef struct packed {
    logic                    go;
    logic                    observe;
    logic                    in_range;
    logic signed [VAL_W-1:0] val;
    logic [WGT_W-1:0]        weight;
  } acc_req_t;

  // Result of one accumulate pass.
  typedef struct packed {
    logic                    done;
    logic [CNT_W-1:0]        count;
    logic [CNT_W-1:0]        total;
    logic signed [SUM_W-1:0] sum;
  } acc_rsp_t;

endpackage

`default_nettype wire

/* rtl/hbo_bound_scan.sv */
// Boundary table and the shared compare unit that walks it one entry per cycle.
// Depends on hbo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hbo_bound_scan
  import hbo_pkg::*;
#(
  parameter int MAX_BOUNDS = MAX_BOUNDS_DEF,
  parameter int IDX_W      = $clog2(MAX_BOUNDS + 1),
  parameter int BA_W       = (MAX_BOUNDS > 1) ? $clog2(MAX_BOUNDS) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    go,
  input  wire logic [IDX_W-1:0]        n,
  input  wire logic signed [VAL_W-1:0] val,
  input  wire logic                    wr_en,
  input  wire logic [BA_W-1:0]         wr_addr,
  input  wire logic signed [VAL_W-1:0] wr_data,
  output logic                         done,
  output logic [IDX_W-1:0]             hit
);

  logic signed [VAL_W-1:0] bnd_mem [MAX_BOUNDS];
  logic signed [VAL_W-1:0] rd_data_r;
  logic [BA_W-1:0]         rd_addr;
  logic [IDX_W-1:0]        idx_r, idx_nxt, idx_inc;
  logic                    active_r, active_nxt;
  logic                    le, last;

  assign idx_inc = idx_r + IDX_W'(1);
  assign le      = (val <= rd_data_r);
  assign last    = (idx_inc == n);
  assign done    = active_r && (le || last);
  assign hit     = le ? idx_r : n;

  always_comb begin
    active_nxt = active_r;
    idx_nxt    = idx_r;
    rd_addr    = '0;
    if (go) begin
      active_nxt = 1'b1;
      idx_nxt    = '0;
    end else if (active_r) begin
      if (done) begin
        active_nxt = 1'b0;
      end else begin
        idx_nxt = idx_inc;
        rd_addr = BA_W'(idx_inc);
      end
    end
  end

  // Read data is registered behind the address, so the entry for idx_r is ready
  // in the cycle where idx_r is compared.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      bnd_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= bnd_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      active_r <= active_nxt;
      idx_r    <= idx_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/hbo_accum.sv */
// Bucket count memory, total count, and the multiply and saturating add for the sum.
// Depends on hbo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hbo_accum
  import hbo_pkg::*;
#(
  parameter int MAX_BOUNDS = MAX_BOUNDS_DEF,
  parameter int IDX_W      = $clog2(MAX_BOUNDS + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire acc_req_t         req,
  input  wire logic [IDX_W-1:0] addr,
  output acc_rsp_t              rsp
);

  localparam int NB = MAX_BOUNDS + 1;

  logic [CNT_W-1:0]        cnt_mem [NB];
  logic [NB-1:0]           vld_r;
  logic [CNT_W-1:0]        rd_data_r;
  logic [IDX_W-1:0]        addr_r;
  logic                    obs_r, rng_r;
  logic                    ph_a_r, ph_b_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [WGT_W:0]   w_s;
  logic [CNT_W-1:0]        total_r;
  logic signed [SUM_W-1:0] sum_r;

  logic [CNT_W-1:0]        old_cnt, new_cnt, new_total;
  logic [CNT_W:0]          cnt_add, tot_add;
  logic [SUM_W:0]          sum_add;
  logic signed [SUM_W-1:0] new_sum;

  assign w_s = {1'b0, req.weight};

  always_comb begin
    old_cnt = (rng_r && vld_r[addr_r]) ? rd_data_r : '0;
    cnt_add = {1'b0, old_cnt} + (CNT_W+1)'(req.weight);
    new_cnt = cnt_add[CNT_W] ? '1 : cnt_add[CNT_W-1:0];
    tot_add = {1'b0, total_r} + (CNT_W+1)'(req.weight);
    new_total = tot_add[CNT_W] ? '1 : tot_add[CNT_W-1:0];
    // One extra bit catches signed overflow; the top two bits disagree then.
    sum_add = {sum_r[SUM_W-1], sum_r} + (SUM_W+1)'(prod_r);
    if (sum_add[SUM_W] != sum_add[SUM_W-1]) begin
      new_sum = sum_add[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      new_sum = sum_add[SUM_W-1:0];
    end
  end

  assign rsp.done  = ph_b_r;
  assign rsp.count = obs_r ? new_cnt : old_cnt;
  assign rsp.total = obs_r ? new_total : total_r;
  assign rsp.sum   = obs_r ? new_sum : sum_r;

  always_ff @(posedge clk) begin
    prod_r    <= $signed(req.val) * w_s;
    rd_data_r <= cnt_mem[addr_r];
    if (ph_b_r && obs_r) begin
      cnt_mem[addr_r] <= new_cnt;
    end
    if (req.go) begin
      addr_r <= addr;
      obs_r  <= req.observe;
      rng_r  <= req.in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_a_r  <= 1'b0;
      ph_b_r  <= 1'b0;
      vld_r   <= '0;
      total_r <= '0;
      sum_r   <= '0;
    end else begin
      ph_a_r <= req.go;
      ph_b_r <= ph_a_r;
      if (ph_b_r && obs_r) begin
        vld_r[addr_r] <= 1'b1;
        total_r       <= new_total;
        sum_r         <= new_sum;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/bucket_histogram_observer.sv */
// Weighted histogram engine: one item accepted per start pulse while not busy.
// Load and read items go from accept straight to the accumulate unit; observe items
// first have the compare unit step through boundaries, one per cycle, until one is
// not below the value or is the last in use (1..n, none when no boundaries are used).
// Results are registered after the accumulate phases and are one-cycle strobes that
// the receiver cannot stall; synchronous active-low reset clears all counts.
`timescale 1ns / 1ps
`default_nettype none

module bucket_histogram_observer
  import hbo_pkg::*;
#(
  parameter int MAX_BOUNDS = MAX_BOUNDS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [1:0]              in_mode,
  input  wire logic signed [VAL_W-1:0] in_sample_value,
  input  wire logic [WGT_W-1:0]        in_weight,
  input  wire logic [SLOT_W-1:0]       in_slot,
  output logic                         out_valid,
  output logic [SLOT_W-1:0]            out_bucket_hit,
  output logic [CNT_W-1:0]             out_bucket_count,
  output logic [CNT_W-1:0]             out_total_count,
  output logic signed [SUM_W-1:0]      out_total_sum,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [SLOT_W-1:0]       cfg_bounds_in_use
);

  localparam int IDX_W = $clog2(MAX_BOUNDS + 1);
  localparam int BA_W  = (MAX_BOUNDS > 1) ? $clog2(MAX_BOUNDS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_ACCUM = 3'b100
  } state_t;

  state_t                  state_r, state_nxt;
  logic [SLOT_W-1:0]       bounds_r;
  logic signed [VAL_W-1:0] val_r;
  logic [WGT_W-1:0]        wgt_r;
  logic [SLOT_W-1:0]       slot_r;
  logic                    obs_r, obs_nxt;
  logic [IDX_W-1:0]        hit_r, hit_nxt;

  logic                    accept;
  logic [IDX_W-1:0]        n_use;
  logic                    slot_load_ok, slot_read_ok;
  logic                    scan_go, scan_done;
  logic [IDX_W-1:0]        scan_hit;
  logic                    bnd_wr;
  acc_req_t                acc_req;
  acc_rsp_t                acc_rsp;
  logic [IDX_W-1:0]        acc_addr;

  logic                    out_valid_r;
  logic [SLOT_W-1:0]       out_hit_r;
  logic [CNT_W-1:0]        out_cnt_r, out_tot_r;
  logic signed [SUM_W-1:0] out_sum_r;

  assign busy      = (state_r != ST_IDLE);
  // The register is never written in the cycle an item is taken.
  assign cfg_ready = !busy && !start;
  assign accept    = start && !busy;

  assign n_use = (32'(bounds_r) < 32'(MAX_BOUNDS)) ? IDX_W'(bounds_r) : IDX_W'(MAX_BOUNDS);
  assign slot_load_ok = (32'(in_slot) < 32'(MAX_BOUNDS));
  assign slot_read_ok = (32'(in_slot) <= 32'(MAX_BOUNDS));
  assign bnd_wr = accept && (in_mode == MODE_LOAD) && slot_load_ok;

  always_comb begin
    state_nxt        = state_r;
    obs_nxt          = obs_r;
    hit_nxt          = hit_r;
    scan_go          = 1'b0;
    acc_req.go       = 1'b0;
    acc_req.observe  = 1'b0;
    acc_req.in_range = 1'b1;
    acc_req.val      = val_r;
    acc_req.weight   = wgt_r;
    acc_addr         = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          obs_nxt = (in_mode == MODE_OBSERVE);
          if (in_mode == MODE_OBSERVE && n_use != '0) begin
            scan_go   = 1'b1;
            state_nxt = ST_SCAN;
          end else begin
            // No boundaries in use means bucket zero is the overflow bucket.
            acc_req.go       = 1'b1;
            acc_req.observe  = (in_mode == MODE_OBSERVE);
            acc_req.in_range = (in_mode == MODE_OBSERVE) || slot_read_ok;
            acc_addr         = (in_mode == MODE_OBSERVE) ? '0 : IDX_W'(in_slot);
            hit_nxt          = '0;
            state_nxt        = ST_ACCUM;
          end
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          acc_req.go      = 1'b1;
          acc_req.observe = 1'b1;
          acc_addr        = scan_hit;
          hit_nxt         = scan_hit;
          state_nxt       = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        if (acc_rsp.done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  hbo_bound_scan #(
    .MAX_BOUNDS (MAX_BOUNDS),
    .IDX_W      (IDX_W),
    .BA_W       (BA_W)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (scan_go),
    .n       (n_use),
    .val     (val_r),
    .wr_en   (bnd_wr),
    .wr_addr (BA_W'(in_slot)),
    .wr_data (in_sample_value),
    .done    (scan_done),
    .hit     (scan_hit)
  );

  hbo_accum #(
    .MAX_BOUNDS (MAX_BOUNDS),
    .IDX_W      (IDX_W)
  ) u_accum (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (acc_req),
    .addr  (acc_addr),
    .rsp   (acc_rsp)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      val_r  <= in_sample_value;
      wgt_r  <= in_weight;
      slot_r <= in_slot;
    end
    hit_r <= hit_nxt;
    obs_r <= obs_nxt;
    if (acc_rsp.done) begin
      out_hit_r <= obs_r ? SLOT_W'(hit_r) : slot_r;
      out_cnt_r <= acc_rsp.count;
      out_tot_r <= acc_rsp.total;
      out_sum_r <= acc_rsp.sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bounds_r    <= BOUNDS_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= acc_rsp.done;
      if (cfg_valid && cfg_ready) begin
        bounds_r <= cfg_bounds_in_use;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_bucket_hit   = out_hit_r;
  assign out_bucket_count = out_cnt_r;
  assign out_total_count  = out_tot_r;
  assign out_total_sum    = out_sum_r;

endmodule

`default_nettype wire

/* rtl/hbo_checker.sv */
// Port-level checks on the histogram observer's command and result timing.
// Depends on hbo_pkg; bound to bucket_histogram_observer below.
`timescale 1ns / 1ps
`default_nettype none

module hbo_checker
  import hbo_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             out_valid,
  input wire logic [CNT_W-1:0] out_total_count
);

  // An accepted item keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("item accepted but block not busy afterwards");

  // A result only follows a busy cycle and is shown once the block is free.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) && !busy))
    else $error("result strobe without a preceding busy cycle");

  // Each item gives a single one-cycle strobe.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // The total count saturates upward and never falls between back-to-back checks.
  a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(out_valid, 3)) |-> (out_total_count >= $past(out_total_count, 3)))
    else $error("total count decreased");

endmodule

bind bucket_histogram_observer hbo_checker u_hbo_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_total_count (out_total_count)
);

`default_nettype wire
